/* src/pnv_pkg.sv */
// ----------------------------------------------------------------------------
// pnv_pkg
// shared types and constants for the phone number validator
// ----------------------------------------------------------------------------
package pnv_pkg;

   localparam int MAX_DIGITS_DEF = 24;
   localparam int UNIT_W         = 16;
   localparam int COUNT_W        = 5;
   localparam int PHASE_W        = 3;
   localparam int ESC_W          = 2;
   localparam int NIB_W          = 4;

   localparam logic [PHASE_W-1:0] PH_START = 3'd0;
   localparam logic [PHASE_W-1:0] PH_MAIN  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_CTI   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DONE  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_FAIL  = 3'd4;

   localparam logic [ESC_W-1:0] ESC_NONE = 2'd0;
   localparam logic [ESC_W-1:0] ESC_HIGH = 2'd1;
   localparam logic [ESC_W-1:0] ESC_LOW  = 2'd2;

   localparam logic [UNIT_W-1:0] CH_PLUS    = 16'h002B;
   localparam logic [UNIT_W-1:0] CH_HASH    = 16'h0023;
   localparam logic [UNIT_W-1:0] CH_STAR    = 16'h002A;
   localparam logic [UNIT_W-1:0] CH_DOT     = 16'h002E;
   localparam logic [UNIT_W-1:0] CH_LPAREN  = 16'h0028;
   localparam logic [UNIT_W-1:0] CH_RPAREN  = 16'h0029;
   localparam logic [UNIT_W-1:0] CH_DASH    = 16'h002D;
   localparam logic [UNIT_W-1:0] CH_COMMA   = 16'h002C;
   localparam logic [UNIT_W-1:0] CH_BANG    = 16'h0021;
   localparam logic [UNIT_W-1:0] CH_SEMI    = 16'h003B;
   localparam logic [UNIT_W-1:0] CH_SLASH   = 16'h002F;
   localparam logic [UNIT_W-1:0] CH_PERCENT = 16'h0025;
   localparam logic [UNIT_W-1:0] CH_SPACE   = 16'h0020;
   localparam logic [UNIT_W-1:0] CH_TAB     = 16'h0009;
   localparam logic [UNIT_W-1:0] CH_CR      = 16'h000D;
   localparam logic [UNIT_W-1:0] CH_ZERO    = 16'h0030;
   localparam logic [UNIT_W-1:0] CH_NINE    = 16'h0039;

   typedef struct packed {
      logic plus;
      logic digit;
      logic sep;
      logic end_mark;
      logic slash;
      logic cti_sym;
   } pnv_class_type;

   typedef struct packed {
      logic               number_valid;
      logic [COUNT_W-1:0] digit_count;
   } pnv_result_type;

endpackage

/* src/pnv_char_class.sv */
// ----------------------------------------------------------------------------
// pnv_char_class
// sorts one decoded character into the classes the parser acts on
// ----------------------------------------------------------------------------
module pnv_char_class
   import pnv_pkg::*;
(
   input  logic [UNIT_W-1:0] ch,
   output pnv_class_type     cls
);

   logic is_space;

   assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));

   always_comb begin
      cls.plus     = (ch == CH_PLUS);
      cls.digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
      cls.sep      = is_space || (ch == CH_HASH) || (ch == CH_STAR) ||
                     (ch == CH_DOT) || (ch == CH_LPAREN) || (ch == CH_RPAREN) ||
                     (ch == CH_DASH) || (ch == CH_COMMA);
      cls.end_mark = (ch == CH_BANG) || (ch == CH_SEMI);
      cls.slash    = (ch == CH_SLASH);
      cls.cti_sym  = (ch == CH_HASH) || (ch == CH_STAR) || (ch == CH_COMMA);
   end

endmodule

/* src/pnv_parser.sv */
// ----------------------------------------------------------------------------
// pnv_parser
// percent decoding and dial-string state, one code unit per step
// ----------------------------------------------------------------------------
module pnv_parser
   import pnv_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [UNIT_W-1:0] code_unit,
   input  logic              cti_mode,
   output pnv_result_type    result
);

   localparam logic [COUNT_W-1:0] DIG_MAX = COUNT_W'(MAX_DIGITS);
   localparam logic [COUNT_W-1:0] DIG_SAT = COUNT_W'(MAX_DIGITS + 1);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [COUNT_W-1:0] digits_ff, digits_in;
   logic               slash_ff, slash_in;
   logic [ESC_W-1:0]   esc_ff, esc_in;
   logic [NIB_W-1:0]   nib_ff, nib_in;

   logic               hex_ok;
   logic [NIB_W-1:0]   hex_val;
   logic [UNIT_W-1:0]  ch;
   logic               ch_ready;
   logic               in_range;
   pnv_class_type      cls;

   pnv_char_class u_class (
      .ch  (ch),
      .cls (cls)
   );

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = '0;
      if ((code_unit >= 16'h0030) && (code_unit <= 16'h0039)) begin
         hex_val = NIB_W'(code_unit - 16'h0030);
      end else if ((code_unit >= 16'h0041) && (code_unit <= 16'h0046)) begin
         hex_val = NIB_W'(code_unit - 16'h0037);
      end else if ((code_unit >= 16'h0061) && (code_unit <= 16'h0066)) begin
         hex_val = NIB_W'(code_unit - 16'h0057);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // decoded character, ready when a plain unit or a finished escape arrives
   always_comb begin
      ch = code_unit;
      ch_ready = 1'b0;
      if ((code_unit != '0) && (phase_ff != PH_FAIL)) begin
         if (esc_ff == ESC_NONE) begin
            ch_ready = (code_unit != CH_PERCENT);
         end else if (hex_ok && (esc_ff != ESC_HIGH)) begin
            ch = {8'h00, nib_ff, hex_val};
            ch_ready = 1'b1;
         end
      end
   end

   assign in_range            = (digits_ff >= COUNT_W'(1)) && (digits_ff <= DIG_MAX);
   assign result.number_valid = (phase_ff != PH_FAIL) && (esc_ff == ESC_NONE) && in_range;
   assign result.digit_count  = digits_ff;

   always_comb begin
      phase_in = phase_ff;
      digits_in = digits_ff;
      slash_in = slash_ff;
      esc_in = esc_ff;
      nib_in = nib_ff;
      if (code_unit == '0) begin
         phase_in = PH_START;
         digits_in = '0;
         slash_in = 1'b0;
         esc_in = ESC_NONE;
         nib_in = '0;
      end else if (phase_ff != PH_FAIL) begin
         if (esc_ff == ESC_NONE) begin
            if (code_unit == CH_PERCENT) begin
               esc_in = ESC_HIGH;
            end
         end else if (!hex_ok) begin
            phase_in = PH_FAIL;
            esc_in = ESC_NONE;
            nib_in = '0;
         end else if (esc_ff == ESC_HIGH) begin
            nib_in = hex_val;
            esc_in = ESC_LOW;
         end else begin
            esc_in = ESC_NONE;
            nib_in = '0;
         end

         if (ch_ready && (phase_ff != PH_DONE)) begin
            if (ch == '0) begin
               phase_in = PH_DONE;
            end else if (phase_ff == PH_CTI) begin
               if (cls.digit || cls.cti_sym) begin
                  slash_in = 1'b0;
               end else if (cls.slash) begin
                  if (slash_ff) begin
                     phase_in = PH_FAIL;
                  end else begin
                     slash_in = 1'b1;
                  end
               end else begin
                  phase_in = PH_FAIL;
               end
            end else if ((phase_ff == PH_START) && cls.plus) begin
               phase_in = PH_MAIN;
            end else begin
               phase_in = PH_MAIN;
               if (cls.digit) begin
                  if (digits_ff < DIG_SAT) begin
                     digits_in = digits_ff + COUNT_W'(1);
                  end
               end else if (cls.sep) begin
                  phase_in = PH_MAIN;
               end else if (cls.end_mark) begin
                  phase_in = cti_mode ? PH_FAIL : PH_DONE;
               end else if (cls.slash && cti_mode && in_range) begin
                  phase_in = PH_CTI;
                  slash_in = 1'b1;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         digits_ff <= '0;
         slash_ff <= 1'b0;
         esc_ff <= ESC_NONE;
         nib_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         digits_ff <= digits_in;
         slash_ff <= slash_in;
         esc_ff <= esc_in;
         nib_ff <= nib_in;
      end
   end

endmodule

/* src/phone_number_validator.sv */
// ----------------------------------------------------------------------------
// phone_number_validator
// checks a percent-escaped dial string, one code unit per transaction
//
// req channel: one UCS-2 code unit per transaction, a zero unit ends the
//   string; req_tuser carries the cti mode flag
// rsp channel: one transaction per string, sent for the zero unit only,
//   with the valid flag and the main-part digit count (saturating)
// rsp path: input register, then output register, which drives rsp_tvalid
// throughput: one code unit per cycle unless a terminator waits; the input register
//   takes a new unit while a finished result waits in the output register
// when the receiver stalls, non-terminating units keep flowing; a second
//   terminator waits in the input register until the output register frees
// reset: clears both valid flags and returns the parser to start of string
// ----------------------------------------------------------------------------
module phone_number_validator
   import pnv_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] code_unit
   input  logic        req_tuser,  // [0] cti_mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [0] number_valid, [5:1] digit_count, [7:6] zero
);

   logic              s1_valid_ff, s1_valid_in;
   logic [UNIT_W-1:0] s1_unit_ff;
   logic              s1_cti_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   pnv_result_type    rsp_data_ff;

   logic              out_free;
   logic              s1_term;
   logic              s1_adv;
   pnv_result_type    result;

   pnv_parser #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_adv),
      .code_unit (s1_unit_ff),
      .cti_mode  (s1_cti_ff),
      .result    (result)
   );

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s1_term     = (s1_unit_ff == '0);
   assign s1_adv      = s1_valid_ff && (!s1_term || out_free);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in = req_tvalid ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_term) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_tready ? s1_valid_in : s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_unit_ff <= req_tdata;
         s1_cti_ff <= req_tuser;
      end
      if (s1_adv && s1_term) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.digit_count, rsp_data_ff.number_valid};

endmodule
